FILE: src/csp_pkg.sv
// Shared types, constants and helper functions for the CD-ROM sector payload extractor.
// No dependencies; csp_in_stage, csp_core and the top level import this package.
`timescale 1ns / 1ps

package csp_pkg;

  // Kind of the sector a result belongs to.
  typedef enum logic [2:0] {
    KIND_AUDIO = 3'd0,
    KIND_MODE1 = 3'd1,
    KIND_FORM1 = 3'd2,
    KIND_FORM2 = 3'd3,
    KIND_BAD   = 3'd4
  } sector_kind_t;

  // Contents of the input register that sits in front of the deframer.
  typedef struct packed {
    logic       valid;
    logic [7:0] raw_byte;
  } byte_stage_t;

  localparam int SYNC_LEN    = 12;
  localparam int SYNC_IDX_W  = $clog2(SYNC_LEN);
  localparam int MODE_POS    = 15;
  localparam int SUBMODE_POS = 18;
  localparam int M1_START    = 16;
  localparam int XA_START    = 24;
  localparam int FORM1_LEN   = 2048;
  localparam int FORM2_LEN   = 2324;
  localparam int M1_LAST     = M1_START + FORM1_LEN - 1;
  localparam int XA_F1_LAST  = XA_START + FORM1_LEN - 1;
  localparam int XA_F2_LAST  = XA_START + FORM2_LEN - 1;

  localparam logic [7:0] MODE_1      = 8'd1;
  localparam logic [7:0] MODE_2      = 8'd2;
  localparam int         XA_FORM_BIT = 5;

  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

  // Expected sync byte: 00 at both ends of the sync field, FF in between.
  function automatic logic [7:0] sync_expected(input logic [SYNC_IDX_W-1:0] idx);
    return (idx == '0 || idx == SYNC_IDX_W'(SYNC_LEN - 1)) ? 8'h00 : 8'hFF;
  endfunction

  // Increment that sticks at the all-ones value.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

FILE: src/csp_byte_if.sv
// Valid/ready channel that carries one raw sector byte per transfer.
// No dependencies.
`timescale 1ns / 1ps

interface csp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

FILE: src/csp_result_if.sv
// Valid/ready channel that carries one extracted payload or status item per transfer.
// No dependencies.
`timescale 1ns / 1ps

interface csp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        last_of_sector;
  logic [2:0]  sector_kind;
  logic        sync_error;
  logic [31:0] sync_error_total;
  logic [31:0] mode1_total;
  logic [31:0] form1_total;
  logic [31:0] form2_total;

  modport source (output valid, output payload_byte, output payload_valid,
                  output last_of_sector, output sector_kind, output sync_error,
                  output sync_error_total, output mode1_total, output form1_total,
                  output form2_total, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input last_of_sector, input sector_kind, input sync_error,
                  input sync_error_total, input mode1_total, input form1_total,
                  input form2_total, output ready);
endinterface

FILE: src/csp_in_stage.sv
// Input register of the extractor: holds one raw byte until the deframer takes it.
// Depends on csp_pkg and csp_byte_if.
`timescale 1ns / 1ps

module csp_in_stage
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  csp_byte_if.sink    in_ch,
  input  logic        take,
  output byte_stage_t stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       load;

  // The register refills in the same cycle that the deframer empties it.
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_ch.raw_byte;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign stage.valid    = valid_r;
  assign stage.raw_byte = byte_r;

endmodule

FILE: src/csp_core.sv
// Deframer core: sector position, header state, saturating counters and result register.
// Depends on csp_pkg and csp_result_if.
`timescale 1ns / 1ps

module csp_core
  import csp_pkg::*;
#(
  parameter int SECTOR_BYTES = 2352
) (
  input  logic         clk,
  input  logic         rst_n,
  input  byte_stage_t  stage,
  output logic         take,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  csp_result_if.source out_ch
);

  localparam int PosW = $clog2(SECTOR_BYTES);
  localparam logic [PosW-1:0] LAST_POS = PosW'(SECTOR_BYTES - 1);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            data_track_r;
  logic            mism_r, mism_nxt;
  logic [7:0]      mode_r, mode_nxt;
  logic            form_r, form_nxt;
  logic [31:0]     sync_cnt_r, sync_cnt_nxt;
  logic [31:0]     m1_cnt_r, m1_cnt_nxt;
  logic [31:0]     f1_cnt_r, f1_cnt_nxt;
  logic [31:0]     f2_cnt_r, f2_cnt_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      byte_r;
  logic            pv_r;
  logic            last_r;
  sector_kind_t    kind_r;
  logic            serr_r;

  logic            miss;
  logic            res_vld;
  logic [7:0]      res_byte;
  logic            res_pv;
  logic            res_last;
  sector_kind_t    res_kind;
  logic            res_serr;
  logic [PosW-1:0] xa_last;

  assign take = stage.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    pos_nxt      = pos_r;
    mism_nxt     = mism_r;
    mode_nxt     = mode_r;
    form_nxt     = form_r;
    sync_cnt_nxt = sync_cnt_r;
    m1_cnt_nxt   = m1_cnt_r;
    f1_cnt_nxt   = f1_cnt_r;
    f2_cnt_nxt   = f2_cnt_r;
    miss         = 1'b0;
    res_vld      = 1'b0;
    res_byte     = stage.raw_byte;
    res_pv       = 1'b1;
    res_last     = 1'b0;
    res_kind     = KIND_AUDIO;
    res_serr     = 1'b0;
    xa_last      = PosW'(XA_F1_LAST);

    if (take) begin
      pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
      if (!data_track_r) begin
        res_vld  = 1'b1;
        res_last = (pos_r == LAST_POS);
      end else begin
        if (pos_r < PosW'(SYNC_LEN)) begin
          miss     = (stage.raw_byte != sync_expected(pos_r[SYNC_IDX_W-1:0]));
          mism_nxt = (pos_r == '0) ? miss : (mism_r | miss);
          if (pos_r == PosW'(SYNC_LEN - 1) && mism_nxt) begin
            sync_cnt_nxt = sat_inc(sync_cnt_r);
          end
        end else if (pos_r == PosW'(MODE_POS)) begin
          mode_nxt = stage.raw_byte;
          if (stage.raw_byte == MODE_1) begin
            m1_cnt_nxt = sat_inc(m1_cnt_r);
          end
        end else if (pos_r == PosW'(SUBMODE_POS)) begin
          form_nxt = stage.raw_byte[XA_FORM_BIT];
          if (mode_r == MODE_2) begin
            if (form_nxt) begin
              f2_cnt_nxt = sat_inc(f2_cnt_r);
            end else begin
              f1_cnt_nxt = sat_inc(f1_cnt_r);
            end
          end
        end

        res_serr = mism_nxt;
        if (mode_nxt == MODE_1) begin
          res_kind = KIND_MODE1;
          res_last = (pos_r == PosW'(M1_LAST));
          res_vld  = (pos_r >= PosW'(M1_START)) && (pos_r <= PosW'(M1_LAST));
        end else if (mode_nxt == MODE_2) begin
          xa_last  = form_nxt ? PosW'(XA_F2_LAST) : PosW'(XA_F1_LAST);
          res_kind = form_nxt ? KIND_FORM2 : KIND_FORM1;
          res_last = (pos_r == xa_last);
          res_vld  = (pos_r >= PosW'(XA_START)) && (pos_r <= xa_last);
        end else if (pos_r == LAST_POS) begin
          res_vld  = 1'b1;
          res_byte = 8'h00;
          res_pv   = 1'b0;
          res_last = 1'b1;
          res_kind = KIND_BAD;
        end
      end
    end

    if (take) begin
      out_valid_nxt = res_vld;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      data_track_r <= 1'b1;
      mism_r       <= 1'b0;
      mode_r       <= '0;
      form_r       <= 1'b0;
      sync_cnt_r   <= '0;
      m1_cnt_r     <= '0;
      f1_cnt_r     <= '0;
      f2_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      mism_r      <= mism_nxt;
      mode_r      <= mode_nxt;
      form_r      <= form_nxt;
      sync_cnt_r  <= sync_cnt_nxt;
      m1_cnt_r    <= m1_cnt_nxt;
      f1_cnt_r    <= f1_cnt_nxt;
      f2_cnt_r    <= f2_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        data_track_r <= cfg_wr_data;
      end
    end
  end

  // Result payload; the totals are read straight from the counters, which
  // move whenever a byte is taken, also when that byte loads no result.
  always_ff @(posedge clk) begin
    if (take && res_vld) begin
      byte_r <= res_byte;
      pv_r   <= res_pv;
      last_r <= res_last;
      kind_r <= res_kind;
      serr_r <= res_serr;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.payload_byte     = byte_r;
  assign out_ch.payload_valid    = pv_r;
  assign out_ch.last_of_sector   = last_r;
  assign out_ch.sector_kind      = kind_r;
  assign out_ch.sync_error       = serr_r;
  assign out_ch.sync_error_total = sync_cnt_r;
  assign out_ch.mode1_total      = m1_cnt_r;
  assign out_ch.form1_total      = f1_cnt_r;
  assign out_ch.form2_total      = f2_cnt_r;

  a_pos_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("sector position ran past the last byte");

  a_bad_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_BAD |-> !pv_r && last_r && byte_r == 8'h00)
    else $error("bad-mode result is not a status-only end-of-sector item");

  a_audio_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_AUDIO |-> pv_r && !serr_r)
    else $error("audio result carries a status or sync flag");

  a_counters_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> sync_cnt_r >= $past(sync_cnt_r) && m1_cnt_r >= $past(m1_cnt_r)
      && f1_cnt_r >= $past(f1_cnt_r) && f2_cnt_r >= $past(f2_cnt_r))
    else $error("a saturating counter went down");

  a_totals_hold_without_take: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(take) |-> $stable(sync_cnt_r) && $stable(m1_cnt_r)
      && $stable(f1_cnt_r) && $stable(f2_cnt_r))
    else $error("counter changed without a byte being processed");

endmodule

FILE: src/cdrom_sector_payload_extractor.sv
// Top level of the CD-ROM raw sector payload extractor.
// Depends on csp_pkg, csp_byte_if, csp_result_if, csp_in_stage and csp_core.
`timescale 1ns / 1ps

// Usage:
// Raw sector bytes arrive on in_ch, one byte per transfer, starting with byte 0 of a
// sector after reset; the block counts positions itself and wraps every SECTOR_BYTES.
// Results leave on out_ch. On an audio track (cfg data_track = 0) every byte comes out
// unchanged. On a data track the sync field and mode byte are checked, and only the
// user data of mode 1, mode 2 form 1 or mode 2 form 2 sectors is delivered, with
// last_of_sector on the final user byte. A sector with any other mode gives a single
// status transfer (payload_valid low) at its last byte. Every result carries the four
// saturating sector counters as they stand after that byte.
// An input transfer reaches its result through the input register and then the result
// register. Throughput is one byte per cycle unless the receiver stalls, set by the
// single pass from the input register through the position compare to the result
// register; a byte that yields no result still makes that pass.
// Reset (rst_n low at a clock edge) clears the position, header state and counters,
// empties both registers and sets data_track to 1.
// When the receiver stalls, the result register holds its item and the input register
// holds one more byte; after that in_ch.ready drops until out_ch.ready returns.
// cfg_wr_en writes cfg_wr_data into data_track at the clock edge; write it only while
// no transfer is in flight.

module cdrom_sector_payload_extractor
  import csp_pkg::*;
#(
  parameter int SECTOR_BYTES = 2352
) (
  input  logic         clk,
  input  logic         rst_n,
  csp_byte_if.sink     in_ch,
  csp_result_if.source out_ch,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  byte_stage_t stage;
  logic        take;

  // Input register: holds one raw byte in front of the core; in_ch.ready follows take.
  csp_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  // Position tracking, header decode, counters and the result register.
  csp_core #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .take        (take),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ch      (out_ch)
  );

endmodule
